@@ hdl/ece_pkg.sv @@
package ece_pkg;

  // Internal fixed-point format
  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int MulW     = 27;
  localparam int OutW     = 19;
  localparam int AddrW    = 5;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [MulW-1:0]  mop_t;

  localparam data_t One     = data_t'(2 ** FracBits);
  localparam data_t HalfOne = One / 2;
  localparam data_t QtrOne  = One / 4;
  localparam data_t TwoOne  = 2 * One;
  localparam data_t TenOne  = 10 * One;

  // 1e-6 in the internal format, rounded, never below one LSB
  localparam int    TolRaw = (17 + 2 ** (24 - FracBits - 1)) >> (24 - FracBits);
  localparam data_t Tol    = data_t'((TolRaw < 1) ? 1 : TolRaw);

  // back overshoot s = 1.70158 * 1.525 and s + 1, Q24 constants rounded to Q16
  localparam data_t BackS  = data_t'((43535357 + 128) >> 8);
  localparam data_t BackS1 = data_t'((60312573 + 128) >> 8);

  // bounce segment offsets 3/4, 15/16, 63/64
  localparam data_t BncC1 = 3 * One / 4;
  localparam data_t BncC2 = 15 * One / 16;
  localparam data_t BncC3 = 63 * One / 64;

  localparam data_t OutMax = data_t'(2 ** (OutW - 1) - 1);
  localparam data_t OutMin = -data_t'(2 ** (OutW - 1));

  typedef enum logic [3:0] {
    CrvHold      = 4'd0,
    CrvLinear    = 4'd1,
    CrvCubicIn   = 4'd2,
    CrvCubicOut  = 4'd3,
    CrvCubicBoth = 4'd4,
    CrvElastic   = 4'd5,
    CrvBounce    = 4'd6,
    CrvBack      = 4'd7,
    CrvBezier    = 4'd8
  } curve_e;

  typedef enum logic [2:0] {
    RegPresent = 3'd0,
    RegX1      = 3'd1,
    RegY1      = 3'd2,
    RegX2      = 3'd3,
    RegY2      = 3'd4
  } reg_idx_e;

  // multiply then shift: R modes round half up, F modes floor
  typedef enum logic [2:0] {
    MulR16 = 3'd0,
    MulR20 = 3'd1,
    MulR22 = 3'd2,
    MulF12 = 3'd3,
    MulF10 = 3'd4
  } mul_mode_e;

  typedef struct packed {
    mul_mode_e mode;
    mop_t      a;
    mop_t      b;
  } mul_req_t;

  typedef struct packed {
    logic                present;
    logic [16:0]         x1;
    logic signed [18:0]  y1;
    logic [16:0]         x2;
    logic signed [18:0]  y2;
  } bez_cfg_t;

  typedef struct packed {
    logic  start;
    data_t num;
    data_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quot;
  } div_rsp_t;

  // 2^(-i/16), Q16
  function automatic data_t exp2_tab(input logic [4:0] i);
    data_t v;
    case (i)
      5'd0:    v = 32'sd65536;
      5'd1:    v = 32'sd62757;
      5'd2:    v = 32'sd60097;
      5'd3:    v = 32'sd57549;
      5'd4:    v = 32'sd55109;
      5'd5:    v = 32'sd52773;
      5'd6:    v = 32'sd50535;
      5'd7:    v = 32'sd48393;
      5'd8:    v = 32'sd46341;
      5'd9:    v = 32'sd44376;
      5'd10:   v = 32'sd42495;
      5'd11:   v = 32'sd40693;
      5'd12:   v = 32'sd38968;
      5'd13:   v = 32'sd37316;
      5'd14:   v = 32'sd35734;
      5'd15:   v = 32'sd34219;
      5'd16:   v = 32'sd32768;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // quarter-wave sine, Q16
  function automatic data_t sin_tab(input logic [4:0] i);
    data_t v;
    case (i)
      5'd0:    v = 32'sd0;
      5'd1:    v = 32'sd6424;
      5'd2:    v = 32'sd12785;
      5'd3:    v = 32'sd19024;
      5'd4:    v = 32'sd25080;
      5'd5:    v = 32'sd30893;
      5'd6:    v = 32'sd36410;
      5'd7:    v = 32'sd41575;
      5'd8:    v = 32'sd46341;
      5'd9:    v = 32'sd50660;
      5'd10:   v = 32'sd54491;
      5'd11:   v = 32'sd57798;
      5'd12:   v = 32'sd60548;
      5'd13:   v = 32'sd62714;
      5'd14:   v = 32'sd64277;
      5'd15:   v = 32'sd65220;
      5'd16:   v = 32'sd65536;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/easing_curve_evaluator.sv @@
// Easing curve evaluator. Takes a signed Q3.16 position and a 4-bit curve code and
// returns one signed Q3.16 eased value with a saturation flag. Positions at or below 0
// give 0 and at or above 1 give 1. All products go through one shared 27x27 multiplier
// with a registered result, and the cubic-bezier Newton quotient through a bit-serial
// divider (one quotient bit a cycle). The bezier curve runs up to NEWTON_STEPS Newton
// steps, each dividing on the divider, which ends early when the quotient saturates,
// then a final evaluation and output. The input is ready again in the cycle the result
// appears; a finished word waits in the output register and does not hold back the next
// accept, but the following result waits inside the block until that word is taken.
// Control points are written over the APB port (present, x1, y1, x2, y2 at 0x0..0x10).
module easing_curve_evaluator #(
  parameter int NEWTON_STEPS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [18:0]        position_i,
  input  logic [3:0]                curve_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [18:0]        eased_value_o,
  output logic                      saturated_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ece_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import ece_pkg::*;

  localparam int IterW = $clog2(NEWTON_STEPS + 1);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRun  = 4'b0010,
    StDiv  = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [3:0]         pc_q, pc_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic [3:0]         curve_q, curve_d;
  logic               fin_q, fin_d;
  data_t              t_q, t_d, u_q, u_d;
  data_t              aa_q, aa_d, au_q, au_d, uu_q, uu_d;
  data_t              acc_q, acc_d, dx_q, dx_d, w0_q, w0_d, w1_q, w1_d;
  logic               out_valid_q, out_valid_d;
  logic signed [18:0] res_q, res_d;
  logic               sat_q, sat_d;

  bez_cfg_t cfg;
  mul_req_t mreq;
  data_t    p;
  div_req_t dreq;
  div_rsp_t drsp;

  ece_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ece_mul u_mul (
    .clk_i (clk_i),
    .req_i (mreq),
    .p_o   (p)
  );

  ece_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  function automatic mul_req_t mk(input mul_mode_e m, input data_t a, input data_t b);
    mul_req_t r;
    r.mode = m;
    r.a    = mop_t'(a);
    r.b    = mop_t'(b);
    return r;
  endfunction

  function automatic data_t half(input data_t v);
    return (v + data_t'(1)) >>> 1;
  endfunction

  function automatic data_t clamp2(input data_t v);
    data_t r;
    r = v;
    if (v < -TwoOne) r = -TwoOne;
    if (v > TwoOne)  r = TwoOne;
    return r;
  endfunction

  function automatic data_t clamp01(input data_t v);
    data_t r;
    r = v;
    if (v < 0)   r = '0;
    if (v > One) r = One;
    return r;
  endfunction

  // shared operand shaping
  logic  lt_half;
  data_t t2, cx;
  assign lt_half = t_q < HalfOne;
  assign t2      = t_q <<< 1;

  always_comb begin
    case (curve_e'(curve_q))
      CrvCubicIn:  cx = t_q;
      CrvCubicOut: cx = t_q - One;
      default:     cx = lt_half ? t_q : t2 - TwoOne;
    endcase
  end

  // elastic: decay 2^-|20t-10| and phase (5t + 1/4) turns
  data_t       k_e, kabs, diff_e, phase, diff_s, sv;
  logic [3:0]  n_e, ei;
  logic [11:0] er;
  logic [1:0]  quad;
  logic [13:0] rs;
  logic [14:0] rr;
  logic [4:0]  idx_s;
  logic [9:0]  rem_s;

  assign k_e    = (t_q <<< 4) + (t_q <<< 2) - TenOne;
  assign kabs   = (k_e < 0) ? -k_e : k_e;
  assign n_e    = kabs[FracBits+3:FracBits];
  assign ei     = kabs[FracBits-1 -: 4];
  assign er     = kabs[FracBits-5:0];
  assign diff_e = exp2_tab({1'b0, ei} + 5'd1) - exp2_tab({1'b0, ei});
  assign phase  = (t_q <<< 2) + t_q + QtrOne;
  assign quad   = phase[FracBits-1 -: 2];
  assign rs     = phase[FracBits-3:0];
  assign rr     = quad[0] ? 15'h4000 - {1'b0, rs} : {1'b0, rs};
  assign idx_s  = rr[14:10];
  assign rem_s  = rr[9:0];
  assign diff_s = sin_tab(idx_s + 5'd1) - sin_tab(idx_s);
  assign sv     = (idx_s == 5'd16) ? sin_tab(idx_s) : sin_tab(idx_s) + p;

  // bounce segment pick
  data_t     xb, x11, wb, cb;
  mul_mode_e mb;
  assign xb  = lt_half ? One - t2 : t2 - One;
  assign x11 = (xb <<< 3) + (xb <<< 1) + xb;

  always_comb begin
    if (x11 < 4 * One) begin
      wb = x11;            cb = '0;    mb = MulR20;
    end else if (x11 < 8 * One) begin
      wb = x11 - 6 * One;  cb = BncC1; mb = MulR20;
    end else if (x11 < TenOne) begin
      wb = x11 - 9 * One;  cb = BncC2; mb = MulR20;
    end else begin
      wb = x11 + x11 - 21 * One; cb = BncC3; mb = MulR22;
    end
  end

  // back and bezier operands
  data_t ub, a_b, c1, c2, dx21, omx2, dxf, err, bo, cub, cbl;
  assign ub   = lt_half ? t2 : t2 - TwoOne;
  assign a_b  = One - u_q;
  assign c1   = fin_q ? data_t'(cfg.y1) : data_t'(cfg.x1);
  assign c2   = fin_q ? data_t'(cfg.y2) : data_t'(cfg.x2);
  assign dx21 = data_t'(cfg.x2) - data_t'(cfg.x1);
  assign omx2 = One - data_t'(cfg.x2);
  assign dxf  = dx_q + p + p + p;
  assign err  = acc_q - t_q;
  assign bo   = p + cb;
  assign cub  = lt_half ? (p <<< 2) : half(p) + One;
  assign cbl  = (cub + t_q + data_t'(1)) >>> 1;

  data_t un;
  assign un = clamp2(u_q - drsp.quot);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q + 4'd1;
    iter_d      = iter_q;
    curve_d     = curve_q;
    fin_d       = fin_q;
    t_d         = t_q;
    u_d         = u_q;
    aa_d        = aa_q;
    au_d        = au_q;
    uu_d        = uu_q;
    acc_d       = acc_q;
    dx_d        = dx_q;
    w0_d        = w0_q;
    w1_d        = w1_q;
    res_d       = res_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mreq        = mk(MulR16, a_b, a_b);
    dreq.start  = 1'b0;
    dreq.num    = err;
    dreq.den    = dxf;

    case (state_q)
      StIdle: begin
        pc_d = '0;
        if (in_valid_i) begin
          curve_d = curve_i;
          t_d     = data_t'(position_i);
          u_d     = data_t'(position_i);
          iter_d  = '0;
          fin_d   = 1'b0;
          if (position_i <= 0) begin
            acc_d   = '0;
            state_d = StDone;
          end else if (data_t'(position_i) >= One) begin
            acc_d   = One;
            state_d = StDone;
          end else begin
            state_d = StRun;
          end
        end
      end

      StRun: begin
        case (curve_e'(curve_q))
          CrvHold: begin
            acc_d   = '0;
            state_d = StDone;
          end
          CrvLinear: begin
            acc_d   = t_q;
            state_d = StDone;
          end
          CrvElastic: begin
            case (pc_q)
              4'd0: mreq = mk(MulF12, diff_e, data_t'(er));
              4'd1: begin
                mreq = mk(MulF10, diff_s, data_t'(rem_s));
                w0_d = (exp2_tab({1'b0, ei}) + p) >>> n_e;
              end
              4'd2: w1_d = quad[1] ? -sv : sv;
              4'd3: mreq = mk(MulR16, w0_q, w1_q);
              default: begin
                acc_d   = lt_half ? -half(p) : half(p) + One;
                state_d = StDone;
              end
            endcase
          end
          CrvBounce: begin
            if (pc_q == 4'd0) begin
              mreq = mk(mb, wb, wb);
            end else begin
              acc_d   = lt_half ? half(One - bo) : half(bo) + HalfOne;
              state_d = StDone;
            end
          end
          CrvBack: begin
            case (pc_q)
              4'd0: mreq = mk(MulR16, ub, ub);
              4'd1: begin
                mreq = mk(MulR16, BackS1, ub);
                w0_d = p;
              end
              4'd2: mreq = mk(MulR16, w0_q, lt_half ? p - BackS : p + BackS);
              default: begin
                acc_d   = lt_half ? half(p) : half(p + TwoOne);
                state_d = StDone;
              end
            endcase
          end
          CrvBezier: begin
            if (!cfg.present) begin
              acc_d   = t_q;
              state_d = StDone;
            end else begin
              case (pc_q)
                4'd0: mreq = mk(MulR16, a_b, a_b);
                4'd1: begin
                  mreq = mk(MulR16, a_b, u_q);
                  aa_d = p;
                end
                4'd2: begin
                  mreq = mk(MulR16, u_q, u_q);
                  au_d = p;
                end
                4'd3: begin
                  mreq = mk(MulR16, aa_q, u_q);
                  uu_d = p;
                end
                4'd4: mreq = mk(MulR16, p, c1);
                4'd5: begin
                  mreq  = mk(MulR16, au_q, u_q);
                  acc_d = p + p + p;
                end
                4'd6: mreq = mk(MulR16, p, c2);
                4'd7: begin
                  mreq  = mk(MulR16, uu_q, u_q);
                  acc_d = acc_q + p + p + p;
                end
                4'd8: begin
                  acc_d = acc_q + p;
                  mreq  = mk(MulR16, aa_q, data_t'(cfg.x1));
                  if (fin_q) state_d = StDone;
                end
                4'd9: begin
                  mreq = mk(MulR16, au_q, dx21);
                  dx_d = p + p + p;
                end
                4'd10: begin
                  mreq = mk(MulR16, uu_q, omx2);
                  dx_d = dx_q + (p <<< 2) + (p <<< 1);
                end
                default: begin
                  // converged or flat slope: finish with the clamped parameter
                  if ((err < Tol && -err < Tol) || (dxf < Tol && -dxf < Tol)) begin
                    u_d   = clamp01(u_q);
                    fin_d = 1'b1;
                    pc_d  = '0;
                  end else begin
                    dreq.start = 1'b1;
                    state_d    = StDiv;
                  end
                end
              endcase
            end
          end
          default: begin
            // cubic family and the blend of cubic in-out with linear
            case (pc_q)
              4'd0: mreq = mk(MulR16, cx, cx);
              4'd1: mreq = mk(MulR16, p, cx);
              default: begin
                case (curve_e'(curve_q))
                  CrvCubicIn:   acc_d = p;
                  CrvCubicOut:  acc_d = p + One;
                  CrvCubicBoth: acc_d = cub;
                  default:      acc_d = cbl;
                endcase
                state_d = StDone;
              end
            endcase
          end
        endcase
      end

      StDiv: begin
        pc_d = '0;
        if (drsp.done) begin
          state_d = StRun;
          iter_d  = iter_q + 1'b1;
          if (iter_q == IterW'(NEWTON_STEPS - 1)) begin
            u_d   = clamp01(un);
            fin_d = 1'b1;
          end else begin
            u_d = un;
          end
        end
      end

      StDone: begin
        pc_d = '0;
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sat_d       = (acc_q > OutMax) || (acc_q < OutMin);
          if (acc_q > OutMax) begin
            res_d = OutW'(OutMax);
          end else if (acc_q < OutMin) begin
            res_d = OutW'(OutMin);
          end else begin
            res_d = OutW'(acc_q);
          end
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pc_q        <= '0;
      iter_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      iter_q      <= iter_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    curve_q <= curve_d;
    t_q     <= t_d;
    u_q     <= u_d;
    aa_q    <= aa_d;
    au_q    <= au_d;
    uu_q    <= uu_d;
    acc_q   <= acc_d;
    dx_q    <= dx_d;
    w0_q    <= w0_d;
    w1_q    <= w1_d;
    res_q   <= res_d;
    sat_q   <= sat_d;
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign eased_value_o = res_q;
  assign saturated_o   = sat_q;

endmodule

@@ hdl/ece_regs.sv @@
module ece_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ece_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output ece_pkg::bez_cfg_t        cfg_o
);
  import ece_pkg::*;

  bez_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegPresent: cfg_d.present = pwdata[0];
        RegX1:      cfg_d.x1      = pwdata[16:0];
        RegY1:      cfg_d.y1      = signed'(pwdata[18:0]);
        RegX2:      cfg_d.x2      = pwdata[16:0];
        RegY2:      cfg_d.y2      = signed'(pwdata[18:0]);
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegPresent: prdata = {31'b0, cfg_q.present};
      RegX1:      prdata = {15'b0, cfg_q.x1};
      RegY1:      prdata = 32'(cfg_q.y1);
      RegX2:      prdata = {15'b0, cfg_q.x2};
      RegY2:      prdata = 32'(cfg_q.y2);
      default:    prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.present <= 1'b0;
      cfg_q.x1      <= 17'd0;
      cfg_q.y1      <= 19'sd0;
      cfg_q.x2      <= 17'd65536;
      cfg_q.y2      <= 19'sd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hdl/ece_mul.sv @@
module ece_mul (
  input  logic              clk_i,
  input  ece_pkg::mul_req_t req_i,
  output ece_pkg::data_t    p_o
);
  import ece_pkg::*;

  logic signed [2*MulW-1:0] prod;
  logic signed [2*MulW-1:0] shifted;
  data_t                    p_q;

  assign prod = req_i.a * req_i.b;

  always_comb begin
    case (req_i.mode)
      MulR16:  shifted = (prod + (2*MulW)'(2 ** 15)) >>> 16;
      MulR20:  shifted = (prod + (2*MulW)'(2 ** 19)) >>> 20;
      MulR22:  shifted = (prod + (2*MulW)'(2 ** 21)) >>> 22;
      MulF12:  shifted = prod >>> 12;
      MulF10:  shifted = prod >>> 10;
      default: shifted = prod >>> 16;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= data_t'(shifted);
  end

  assign p_o = p_q;

endmodule

@@ hdl/ece_div.sv @@
module ece_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ece_pkg::div_req_t req_i,
  output ece_pkg::div_rsp_t rsp_o
);
  import ece_pkg::*;

  // quotients at or beyond 2^QuotBits land outside the clamp anyway: saturate
  localparam int QuotBits = FracBits + 3;
  localparam int WideW    = DataW + QuotBits;
  localparam int CntW     = $clog2(QuotBits);

  logic                busy_q, done_q, neg_q;
  logic [CntW-1:0]     cnt_q;
  logic [WideW-1:0]    rem_q, dsr_q;
  logic [QuotBits:0]   quo_q;

  logic [DataW-1:0]    num_mag, den_mag;
  logic [WideW-1:0]    num_wide, den_top;
  logic [WideW:0]      trial;
  logic                ge;
  data_t               mag;

  assign num_mag  = req_i.num[DataW-1] ? DataW'(-req_i.num) : DataW'(req_i.num);
  assign den_mag  = req_i.den[DataW-1] ? DataW'(-req_i.den) : DataW'(req_i.den);
  assign num_wide = WideW'(num_mag) << FracBits;
  assign den_top  = WideW'(den_mag) << QuotBits;
  assign trial    = {1'b0, rem_q} - {1'b0, dsr_q};
  assign ge       = ~trial[WideW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= ~(num_wide >= den_top);
        done_q <= (num_wide >= den_top);
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[DataW-1] ^ req_i.den[DataW-1];
      rem_q <= num_wide;
      dsr_q <= WideW'(den_mag) << (QuotBits - 1);
      cnt_q <= CntW'(QuotBits - 1);
      if (num_wide >= den_top) begin
        quo_q <= (QuotBits+1)'(1) << QuotBits;
      end else begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      // one quotient bit a cycle, restoring
      if (ge) begin
        rem_q <= trial[WideW-1:0];
      end
      quo_q <= {quo_q[QuotBits-1:0], ge};
      dsr_q <= dsr_q >> 1;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign mag        = data_t'(quo_q);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -mag : mag;

endmodule
